// ===== hw/rtl/sorted_key_count_table_macros.svh =====
// assertion macros for the sorted key count table rtl
// depends on nothing; included by the top level, which carries concurrent checks
`ifndef SORTED_KEY_COUNT_TABLE_MACROS_SVH
`define SORTED_KEY_COUNT_TABLE_MACROS_SVH
`ifndef NO_ASSERTIONS
// property checked on every edge outside reset
`define SKTC_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition that must never hold outside reset
`define SKTC_NEVER(name, clk, rst_n, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SKTC_ASSERT(name, clk, rst_n, prop, msg)
`define SKTC_NEVER(name, clk, rst_n, cond, msg)
`endif
`endif

// ===== hw/rtl/sktc_pkg.sv =====
// types, codes and saturating arithmetic for the sorted key count table
// depends on nothing; used by sktc_cell, sktc_tree and the top level
`timescale 1ns / 1ps
package sktc_pkg;
	localparam int DEF_CAPACITY = 64;
	localparam int DEF_KEY_BITS = 20;
	localparam int KEY_FIELD_W  = 20;
	localparam int AMT_W        = 31;
	localparam int CNT_W        = 32;
	localparam int S_DATA_W     = 56;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RED,
		S_UPD
	} state_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic                    upd;
		logic                    ins;
		logic signed [CNT_W-1:0] new_count;
	} cell_ctl_t;

	function automatic logic signed [CNT_W-1:0] sat_acc(
		input logic signed [CNT_W-1:0] a,
		input logic [AMT_W-1:0]        b,
		input logic                    sub
	);
		logic signed [CNT_W:0] s;
		s = sub ? ($signed({a[CNT_W-1], a}) - $signed({2'b00, b}))
		        : ($signed({a[CNT_W-1], a}) + $signed({2'b00, b}));
		if (s[CNT_W] != s[CNT_W-1]) begin
			return s[CNT_W] ? {1'b1, {(CNT_W-1){1'b0}}} : {1'b0, {(CNT_W-1){1'b1}}};
		end
		return s[CNT_W-1:0];
	endfunction
endpackage

// ===== hw/rtl/sorted_key_count_table.sv =====
// top level of the sorted key count table: controller, chain of cells, hit tree
// depends on sktc_pkg, sktc_cell, sktc_tree and sorted_key_count_table_macros.svh
`timescale 1ns / 1ps
// usage
//   slave channel s_*: one transaction per operation; s_tuser carries the
//   operation code (add, remove, lookup, clear), s_tdata carries key and amount
//   master channel m_*: exactly one result transaction per operation, in order;
//   m_tdata carries key count, running total and entry count, m_tuser the status
//   the table is a row of CAPACITY cells kept in ascending key order; every cell
//   compares its key with the broadcast key in parallel and an insert shifts
//   each later cell from its lower neighbour, all at the same clock edge
//   sequence: accept registers the operation; the registered hit tree then
//   settles through its leaf register and each level of nodes up to the root,
//   and an update step applies the operation and loads the output register;
//   one operation at a time: a new one is accepted only once the last has left
//   its update step, so the rate is bound by the depth of the hit tree
//   a finished result waits in the output register while the next operation
//   is accepted; if the receiver stalls, that next operation holds in its
//   update cycle until the output register frees
//   reset clears the fill count, the running total and the handshakes; slot
//   contents are not cleared, slots at or above the fill count are never used
module sorted_key_count_table #(
	parameter int CAPACITY = sktc_pkg::DEF_CAPACITY,
	parameter int KEY_BITS = sktc_pkg::DEF_KEY_BITS,
	localparam int EW      = $clog2(CAPACITY + 1),
	localparam int M_W     = ((2 * sktc_pkg::CNT_W + EW + 7) / 8) * 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [sktc_pkg::S_DATA_W-1:0] s_tdata,  // key[19:0], amount[50:20], zero pad
	input  logic [1:0]                    s_tuser,  // operation
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [M_W-1:0]                m_tdata,  // key_count, total_count, entry_count, pad
	output logic [1:0]                    m_tuser   // status
);
	import sktc_pkg::*;

	localparam int LV = $clog2(CAPACITY);
	localparam int CW = $clog2(LV + 2);

	state_t                  state_q, state_d;
	logic [CW-1:0]           wait_q;
	op_t                     op_q;
	logic [KEY_BITS-1:0]     key_q;
	logic [AMT_W-1:0]        amt_q;
	logic [EW-1:0]           used_q, used_d;
	logic signed [CNT_W-1:0] total_q, total_d;

	logic                    out_valid_q;
	logic [M_W-1:0]          out_data_q;
	status_t                 out_status_q;

	logic                    accept, out_free, out_load;
	cell_ctl_t               ctl;
	logic signed [CNT_W-1:0] kc_d;
	status_t                 status_d;

	logic [CAPACITY-1:0]     lt, eq;
	logic [KEY_BITS-1:0]     cell_key [CAPACITY];
	logic signed [CNT_W-1:0] cell_count [CAPACITY];
	logic [CNT_W:0]          leaf [CAPACITY];
	logic [CNT_W:0]          root;
	logic                    found;
	logic signed [CNT_W-1:0] hit_count;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == S_IDLE);
	assign found     = root[CNT_W];
	assign hit_count = root[CNT_W-1:0];

	// controller state and operation registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wait_q  <= '0;
			used_q  <= '0;
			total_q <= '0;
		end else begin
			state_q <= state_d;
			wait_q  <= (state_q == S_RED) ? wait_q + 1'b1 : '0;
			if (out_load) begin
				used_q  <= used_d;
				total_q <= total_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op_t'(s_tuser);
			key_q <= KEY_BITS'(s_tdata[KEY_FIELD_W-1:0]);
			amt_q <= s_tdata[KEY_FIELD_W+AMT_W-1:KEY_FIELD_W];
		end
	end

	// next state and the result of the operation
	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		ctl      = '0;
		kc_d     = '0;
		status_d = ST_OK;
		used_d   = used_q;
		total_d  = total_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_RED;
				end
			end
			S_RED: begin
				// leaves plus LV tree levels must settle
				if (wait_q == CW'(LV)) begin
					state_d = S_UPD;
				end
			end
			S_UPD: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
					unique case (op_q)
						OP_ADD: begin
							if (found) begin
								ctl.upd       = 1'b1;
								ctl.new_count = sat_acc(hit_count, amt_q, 1'b0);
								kc_d          = ctl.new_count;
								total_d       = sat_acc(total_q, amt_q, 1'b0);
							end else if (used_q == EW'(CAPACITY)) begin
								status_d = ST_FULL;
							end else begin
								ctl.ins       = 1'b1;
								ctl.new_count = $signed({1'b0, amt_q});
								kc_d          = ctl.new_count;
								used_d        = used_q + 1'b1;
								total_d       = sat_acc(total_q, amt_q, 1'b0);
							end
						end
						OP_REMOVE: begin
							if (found) begin
								ctl.upd       = 1'b1;
								ctl.new_count = sat_acc(hit_count, amt_q, 1'b1);
								kc_d          = ctl.new_count;
								total_d       = sat_acc(total_q, amt_q, 1'b1);
							end else begin
								status_d = ST_NOT_FOUND;
							end
						end
						OP_LOOKUP: begin
							kc_d = found ? hit_count : '0;
						end
						OP_CLEAR: begin
							used_d  = '0;
							total_d = '0;
						end
						default: begin
							status_d = ST_OK;
						end
					endcase
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// output register parts the update from the receiver
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q   <= M_W'({used_d, total_d, kc_d});
			out_status_q <= status_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_status_q;

	// chain of cells, each fed by its lower neighbour, the first by the broadcast key and count
	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			logic                    p_lt;
			logic [KEY_BITS-1:0]     p_key;
			logic signed [CNT_W-1:0] p_count;
			if (g == 0) begin : g_first
				assign p_lt    = 1'b1;
				assign p_key   = key_q;
				assign p_count = ctl.new_count;
			end else begin : g_next
				assign p_lt    = lt[g-1];
				assign p_key   = cell_key[g-1];
				assign p_count = cell_count[g-1];
			end
			sktc_cell #(
				.IDX      (g),
				.KEY_BITS (KEY_BITS),
				.UW       (EW)
			) u_cell (
				.clk        (clk),
				.key        (key_q),
				.used       (used_q),
				.ctl        (ctl),
				.prev_lt    (p_lt),
				.prev_key   (p_key),
				.prev_count (p_count),
				.lt         (lt[g]),
				.eq         (eq[g]),
				.key_out    (cell_key[g]),
				.count_out  (cell_count[g])
			);
			assign leaf[g] = eq[g] ? {1'b1, cell_count[g]} : '0;
		end
	endgenerate

	sktc_tree #(
		.N (CAPACITY),
		.W (CNT_W + 1)
	) u_tree (
		.clk  (clk),
		.leaf (leaf),
		.root (root)
	);

	`include "sorted_key_count_table_macros.svh"

	`SKTC_NEVER(a_used_bound, clk, arst_n, used_q > EW'(CAPACITY), "fill count above capacity")
	`SKTC_ASSERT(a_accept_red, clk, arst_n, accept |=> state_q == S_RED, "accept not followed by reduction")
	`SKTC_ASSERT(a_full_only_full, clk, arst_n, out_load && status_d == ST_FULL |-> used_q == EW'(CAPACITY) && op_q == OP_ADD, "full status on a table with room")
	`SKTC_ASSERT(a_clear_zero, clk, arst_n, out_load && op_q == OP_CLEAR |=> used_q == '0 && total_q == '0, "clear left state behind")
	`SKTC_NEVER(a_load_busy_out, clk, arst_n, out_load && out_valid_q && !m_tready, "result overwritten before taken")
endmodule

// ===== hw/rtl/sktc_cell.sv =====
// one slot of the sorted chain: key, count, compare and shift from neighbour
// depends on sktc_pkg
`timescale 1ns / 1ps
module sktc_cell #(
	parameter int IDX      = 0,
	parameter int KEY_BITS = sktc_pkg::DEF_KEY_BITS,
	parameter int UW       = 7
) (
	input  logic                             clk,
	input  logic [KEY_BITS-1:0]              key,
	input  logic [UW-1:0]                    used,
	input  sktc_pkg::cell_ctl_t              ctl,
	input  logic                             prev_lt,
	input  logic [KEY_BITS-1:0]              prev_key,
	input  logic signed [sktc_pkg::CNT_W-1:0] prev_count,
	output logic                             lt,
	output logic                             eq,
	output logic [KEY_BITS-1:0]              key_out,
	output logic signed [sktc_pkg::CNT_W-1:0] count_out
);
	import sktc_pkg::*;

	logic [KEY_BITS-1:0]     key_q;
	logic signed [CNT_W-1:0] count_q;
	logic                    occ;

	assign occ       = UW'(IDX) < used;
	assign lt        = occ && (key_q < key);
	assign eq        = occ && (key_q == key);
	assign key_out   = key_q;
	assign count_out = count_q;

	always_ff @(posedge clk) begin
		if (ctl.upd && eq) begin
			count_q <= ctl.new_count;
		end else if (ctl.ins && prev_lt && !lt) begin
			key_q   <= key;
			count_q <= ctl.new_count;
		end else if (ctl.ins && !prev_lt) begin
			key_q   <= prev_key;
			count_q <= prev_count;
		end
	end
endmodule

// ===== hw/rtl/sktc_tree.sv =====
// registered or-tree that gathers the hit flag and count of the matching cell
// depends on sktc_pkg
`timescale 1ns / 1ps
module sktc_tree #(
	parameter int N = sktc_pkg::DEF_CAPACITY,
	parameter int W = sktc_pkg::CNT_W + 1
) (
	input  logic         clk,
	input  logic [W-1:0] leaf [N],
	output logic [W-1:0] root
);
	import sktc_pkg::*;

	localparam int LV = $clog2(N);
	localparam int P  = 1 << LV;

	logic [W-1:0] node_q [1:2*P-1];

	// one tree level per cycle, with a register for the leaves and for each level of nodes up to the root
	genvar g;
	generate
		for (g = 0; g < P; g++) begin : g_leaf
			if (g < N) begin : g_real
				always_ff @(posedge clk) begin
					node_q[P+g] <= leaf[g];
				end
			end else begin : g_pad
				always_ff @(posedge clk) begin
					node_q[P+g] <= '0;
				end
			end
		end
		for (g = 1; g < P; g++) begin : g_node
			always_ff @(posedge clk) begin
				node_q[g] <= node_q[2*g] | node_q[2*g+1];
			end
		end
	endgenerate

	assign root = node_q[1];
endmodule
